[hdl/ifb_pkg.sv]
// shared constants, types and helpers of the insert frame builder
// no dependencies
`default_nettype none

package ifb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NSTAGE        = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  localparam int PT_W   = 32;
  localparam int SC_W   = 24;
  localparam int ID_W   = 16;
  localparam int ANG_W  = 16;
  localparam int OX_W   = PT_W + ID_W;
  localparam int CS_W   = FRAC_BITS + 3;
  localparam int Z_W    = 34;
  localparam int AM_W   = CS_W + SC_W - FRAC_BITS + 1;
  localparam int WIDE_W = 64;

  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam logic signed [CS_W-1:0] X_INIT =
    CS_W'((GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  localparam logic [1:0] NORMAL_POS = 2'd0;
  localparam logic [1:0] NORMAL_NEG = 2'd1;

  typedef struct packed {
    logic signed [PT_W-1:0] ins_x;
    logic signed [PT_W-1:0] ins_y;
    logic signed [PT_W-1:0] base_x;
    logic signed [PT_W-1:0] base_y;
    logic signed [SC_W-1:0] scale_x;
    logic signed [SC_W-1:0] scale_y;
    logic signed [OX_W-1:0] ox;
    logic signed [OX_W-1:0] oy;
    logic                   neg;
    logic                   flip;
    logic [1:0]             status;
  } side_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // round to FRAC_BITS fraction bits, half up
  function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] t;
    t = p + (WIDE_W'(1) <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

[hdl/insert_frame_builder_top.sv]
// insert frame builder: cordic sine/cosine, product and saturation pipeline
// depends on ifb_pkg
// from start to done: entry register, NSTAGE cordic stages, then stages m0 to m5
// throughput: one item per cycle, busy is always low; one pipeline stage per cordic step
// results appear on done for one cycle and cannot be stalled
// rst is synchronous and clears all valid bits; data registers are not reset
`default_nettype none

module insert_frame_builder_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [ifb_pkg::PT_W-1:0] ins_x,
  input  wire logic signed [ifb_pkg::PT_W-1:0] ins_y,
  input  wire logic signed [ifb_pkg::PT_W-1:0] base_x,
  input  wire logic signed [ifb_pkg::PT_W-1:0] base_y,
  input  wire logic signed [ifb_pkg::SC_W-1:0] scale_x,
  input  wire logic signed [ifb_pkg::SC_W-1:0] scale_y,
  input  wire logic signed [ifb_pkg::PT_W-1:0] spacing_x,
  input  wire logic signed [ifb_pkg::PT_W-1:0] spacing_y,
  input  wire logic [ifb_pkg::ANG_W-1:0]       angle,
  input  wire logic [1:0]                      normal_mode,
  input  wire logic signed [ifb_pkg::ID_W-1:0] column,
  input  wire logic signed [ifb_pkg::ID_W-1:0] row,
  output logic                                 done,
  output logic signed [ifb_pkg::SC_W-1:0]      matrix_a,
  output logic signed [ifb_pkg::SC_W-1:0]      matrix_b,
  output logic signed [ifb_pkg::SC_W-1:0]      matrix_c,
  output logic signed [ifb_pkg::SC_W-1:0]      matrix_d,
  output logic signed [ifb_pkg::PT_W-1:0]      shift_x,
  output logic signed [ifb_pkg::PT_W-1:0]      shift_y,
  output logic [1:0]                           status
);

  import ifb_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] MAX_M = WIDE_W'((64'sd1 <<< (SC_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] MIN_M = -MAX_M - 1;
  localparam logic signed [WIDE_W-1:0] MAX_T = WIDE_W'((64'sd1 <<< (PT_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] MIN_T = -MAX_T - 1;

  assign busy = 1'b0;

  // entry stage
  side_t                  side_in;
  logic signed [Z_W-1:0]  z_in;
  logic signed [Z_W-1:0]  z_raw;

  always_comb begin
    z_raw = $signed({{(Z_W-ANG_W-16){1'b0}}, angle, 16'b0});
    side_in.ins_x   = ins_x;
    side_in.ins_y   = ins_y;
    side_in.base_x  = base_x;
    side_in.base_y  = base_y;
    side_in.scale_x = scale_x;
    side_in.scale_y = scale_y;
    side_in.ox      = OX_W'(spacing_x) * OX_W'(column);
    side_in.oy      = OX_W'(spacing_y) * OX_W'(row);
    side_in.neg     = (normal_mode == NORMAL_NEG);
    side_in.flip    = 1'b0;
    z_in            = z_raw;
    case (angle[ANG_W-1:ANG_W-2])
      2'b01, 2'b10: begin
        z_in         = z_raw - (Z_W'(1) <<< 31);
        side_in.flip = 1'b1;
      end
      2'b11: begin
        z_in = z_raw - (Z_W'(1) <<< 32);
      end
      default: begin
        z_in = z_raw;
      end
    endcase
    if (column < 0 || row < 0 || scale_x == '0 || scale_y == '0) begin
      side_in.status = ST_INVALID;
    end else if (normal_mode != NORMAL_POS && normal_mode != NORMAL_NEG) begin
      side_in.status = ST_UNSUP;
    end else begin
      side_in.status = ST_OK;
    end
  end

  // cordic chain
  logic signed [CS_W-1:0] cx [0:NSTAGE];
  logic signed [CS_W-1:0] cy [0:NSTAGE];
  logic signed [Z_W-1:0]  cz [0:NSTAGE];
  side_t                  cside [0:NSTAGE];
  logic [NSTAGE:0]        cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= start;
    end
    cx[0]    <= X_INIT;
    cy[0]    <= '0;
    cz[0]    <= z_in;
    cside[0] <= side_in;
  end

  for (genvar i = 0; i < NSTAGE; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN = $signed({{(Z_W-32){1'b0}}, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      if (!cz[i][Z_W-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN;
      end
      cside[i+1] <= cside[i];
    end
  end

  // m0: quadrant fold
  logic                   v0;
  side_t                  s0;
  logic signed [CS_W-1:0] cs0, sn0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= cv[NSTAGE];
    end
    s0  <= cside[NSTAGE];
    cs0 <= cside[NSTAGE].flip ? -cx[NSTAGE] : cx[NSTAGE];
    sn0 <= cside[NSTAGE].flip ? -cy[NSTAGE] : cy[NSTAGE];
  end

  // m1: scale and offset partial products
  localparam int PS_W = CS_W + SC_W;
  localparam int PH_W = CS_W + OX_W - F;
  localparam int PL_W = CS_W + F + 1;

  logic                      v1;
  side_t                     s1;
  logic signed [PS_W-1:0]    p_csx, p_ssx, p_ssy, p_csy;
  logic signed [PH_W-1:0]    h_cox, h_soy, h_sox, h_coy;
  logic signed [PL_W-1:0]    l_cox, l_soy, l_sox, l_coy;
  logic signed [OX_W-F-1:0]  ox_hi, oy_hi;
  logic signed [F:0]         ox_lo, oy_lo;

  assign ox_hi = s0.ox[OX_W-1:F];
  assign oy_hi = s0.oy[OX_W-1:F];
  assign ox_lo = $signed({1'b0, s0.ox[F-1:0]});
  assign oy_lo = $signed({1'b0, s0.oy[F-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1    <= s0;
    p_csx <= PS_W'(cs0) * PS_W'(s0.scale_x);
    p_ssx <= PS_W'(sn0) * PS_W'(s0.scale_x);
    p_ssy <= PS_W'(sn0) * PS_W'(s0.scale_y);
    p_csy <= PS_W'(cs0) * PS_W'(s0.scale_y);
    h_cox <= PH_W'(cs0) * PH_W'(ox_hi);
    h_soy <= PH_W'(sn0) * PH_W'(oy_hi);
    h_sox <= PH_W'(sn0) * PH_W'(ox_hi);
    h_coy <= PH_W'(cs0) * PH_W'(oy_hi);
    l_cox <= PL_W'(cs0) * PL_W'(ox_lo);
    l_soy <= PL_W'(sn0) * PL_W'(oy_lo);
    l_sox <= PL_W'(sn0) * PL_W'(ox_lo);
    l_coy <= PL_W'(cs0) * PL_W'(oy_lo);
  end

  // m2: matrix entries and rotated array offset
  logic                     v2;
  side_t                    s2;
  logic signed [AM_W-1:0]   ma, mb, mc, md;
  logic signed [WIDE_W-1:0] rx, ry;
  logic signed [WIDE_W-1:0] r_a, r_b, r_c, r_d, t_cx, t_sy, t_sx, t_cy;

  always_comb begin
    r_a  = rnd(WIDE_W'(p_csx));
    r_b  = rnd(WIDE_W'(p_ssx));
    r_c  = rnd(WIDE_W'(p_ssy));
    r_d  = rnd(WIDE_W'(p_csy));
    t_cx = WIDE_W'(h_cox) + rnd(WIDE_W'(l_cox));
    t_sy = WIDE_W'(h_soy) + rnd(WIDE_W'(l_soy));
    t_sx = WIDE_W'(h_sox) + rnd(WIDE_W'(l_sox));
    t_cy = WIDE_W'(h_coy) + rnd(WIDE_W'(l_coy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2 <= s1;
    ma <= s1.neg ? -AM_W'(r_a) : AM_W'(r_a);
    mb <= AM_W'(r_b);
    mc <= s1.neg ? AM_W'(r_c) : -AM_W'(r_c);
    md <= AM_W'(r_d);
    rx <= s1.neg ? (t_sy - t_cx) : (t_cx - t_sy);
    ry <= t_sx + t_cy;
  end

  // m3: base point partial products
  localparam int BH_W = AM_W + PT_W - F;
  localparam int BL_W = AM_W + F + 1;

  logic                     v3;
  side_t                    s3;
  logic signed [AM_W-1:0]   ma3, mb3, mc3, md3;
  logic signed [WIDE_W-1:0] rx3, ry3;
  logic signed [BH_W-1:0]   h_abx, h_cby, h_bbx, h_dby;
  logic signed [BL_W-1:0]   l_abx, l_cby, l_bbx, l_dby;
  logic signed [PT_W-F-1:0] bx_hi, by_hi;
  logic signed [F:0]        bx_lo, by_lo;

  assign bx_hi = s2.base_x[PT_W-1:F];
  assign by_hi = s2.base_y[PT_W-1:F];
  assign bx_lo = $signed({1'b0, s2.base_x[F-1:0]});
  assign by_lo = $signed({1'b0, s2.base_y[F-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3    <= s2;
    ma3   <= ma;
    mb3   <= mb;
    mc3   <= mc;
    md3   <= md;
    rx3   <= rx;
    ry3   <= ry;
    h_abx <= BH_W'(ma) * BH_W'(bx_hi);
    h_cby <= BH_W'(mc) * BH_W'(by_hi);
    h_bbx <= BH_W'(mb) * BH_W'(bx_hi);
    h_dby <= BH_W'(md) * BH_W'(by_hi);
    l_abx <= BL_W'(ma) * BL_W'(bx_lo);
    l_cby <= BL_W'(mc) * BL_W'(by_lo);
    l_bbx <= BL_W'(mb) * BL_W'(bx_lo);
    l_dby <= BL_W'(md) * BL_W'(by_lo);
  end

  // m4: translation
  logic                     v4;
  side_t                    s4;
  logic signed [AM_W-1:0]   ma4, mb4, mc4, md4;
  logic signed [WIDE_W-1:0] tx, ty;
  logic signed [WIDE_W-1:0] mx, my, ix;

  always_comb begin
    mx = WIDE_W'(h_abx) + WIDE_W'(h_cby) + rnd(WIDE_W'(l_abx) + WIDE_W'(l_cby));
    my = WIDE_W'(h_bbx) + WIDE_W'(h_dby) + rnd(WIDE_W'(l_bbx) + WIDE_W'(l_dby));
    ix = s3.neg ? -WIDE_W'(s3.ins_x) : WIDE_W'(s3.ins_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4  <= s3;
    ma4 <= ma3;
    mb4 <= mb3;
    mc4 <= mc3;
    md4 <= md3;
    tx  <= ix + rx3 - mx;
    ty  <= WIDE_W'(s3.ins_y) + ry3 - my;
  end

  // m5: saturation and status
  logic signed [SC_W-1:0] sa, sb, sc, sd;
  logic signed [PT_W-1:0] stx, sty;
  logic [5:0]             ovf;
  logic signed [WIDE_W-1:0] wa, wb, wc, wd;

  always_comb begin
    wa = WIDE_W'(ma4);
    wb = WIDE_W'(mb4);
    wc = WIDE_W'(mc4);
    wd = WIDE_W'(md4);
    ovf[0] = (wa > MAX_M) || (wa < MIN_M);
    ovf[1] = (wb > MAX_M) || (wb < MIN_M);
    ovf[2] = (wc > MAX_M) || (wc < MIN_M);
    ovf[3] = (wd > MAX_M) || (wd < MIN_M);
    ovf[4] = (tx > MAX_T) || (tx < MIN_T);
    ovf[5] = (ty > MAX_T) || (ty < MIN_T);
    sa  = ovf[0] ? (wa[WIDE_W-1] ? SC_W'(MIN_M) : SC_W'(MAX_M)) : SC_W'(ma4);
    sb  = ovf[1] ? (wb[WIDE_W-1] ? SC_W'(MIN_M) : SC_W'(MAX_M)) : SC_W'(mb4);
    sc  = ovf[2] ? (wc[WIDE_W-1] ? SC_W'(MIN_M) : SC_W'(MAX_M)) : SC_W'(mc4);
    sd  = ovf[3] ? (wd[WIDE_W-1] ? SC_W'(MIN_M) : SC_W'(MAX_M)) : SC_W'(md4);
    stx = ovf[4] ? (tx[WIDE_W-1] ? PT_W'(MIN_T) : PT_W'(MAX_T)) : PT_W'(tx);
    sty = ovf[5] ? (ty[WIDE_W-1] ? PT_W'(MIN_T) : PT_W'(MAX_T)) : PT_W'(ty);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    if (s4.status != ST_OK) begin
      matrix_a <= '0;
      matrix_b <= '0;
      matrix_c <= '0;
      matrix_d <= '0;
      shift_x  <= '0;
      shift_y  <= '0;
      status   <= s4.status;
    end else begin
      matrix_a <= sa;
      matrix_b <= sb;
      matrix_c <= sc;
      matrix_d <= sd;
      shift_x  <= stx;
      shift_y  <= sty;
      status   <= (ovf != '0) ? ST_OVF : ST_OK;
    end
  end

endmodule

`default_nettype wire

[verif/insert_frame_builder_checker.sv]
// frame checker: watches start/done transfers of insert_frame_builder_top,
// predicts each frame and compares it field by field; depends on ifb_pkg
module insert_frame_builder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [ifb_pkg::PT_W-1:0] ins_x,
  input  logic signed [ifb_pkg::PT_W-1:0] ins_y,
  input  logic signed [ifb_pkg::PT_W-1:0] base_x,
  input  logic signed [ifb_pkg::PT_W-1:0] base_y,
  input  logic signed [ifb_pkg::SC_W-1:0] scale_x,
  input  logic signed [ifb_pkg::SC_W-1:0] scale_y,
  input  logic signed [ifb_pkg::PT_W-1:0] spacing_x,
  input  logic signed [ifb_pkg::PT_W-1:0] spacing_y,
  input  logic [ifb_pkg::ANG_W-1:0]       angle,
  input  logic [1:0]                      normal_mode,
  input  logic signed [ifb_pkg::ID_W-1:0] column,
  input  logic signed [ifb_pkg::ID_W-1:0] row,
  input  logic                            done,
  input  logic signed [ifb_pkg::SC_W-1:0] matrix_a,
  input  logic signed [ifb_pkg::SC_W-1:0] matrix_b,
  input  logic signed [ifb_pkg::SC_W-1:0] matrix_c,
  input  logic signed [ifb_pkg::SC_W-1:0] matrix_d,
  input  logic signed [ifb_pkg::PT_W-1:0] shift_x,
  input  logic signed [ifb_pkg::PT_W-1:0] shift_y,
  input  logic [1:0]                      status,
  output int                              fail_count,
  output int                              pending
);

  import ifb_pkg::*;

  typedef struct {
    logic signed [SC_W-1:0] ma, mb, mc, md;
    logic signed [PT_W-1:0] tx, ty;
    logic [1:0]             st;
  } frame_t;

  localparam longint ATAN_TURN[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  frame_t frame_q[$];
  int     n_frames;

  function automatic longint round_q(input longint p);
    return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // k * v in Q format, split so the partial products stay in 64 bits
  function automatic longint scaled_mul(input longint k, input longint v);
    longint lo, hi;
    lo = v & 64'hFFFFFF;
    hi = (v - lo) >>> 24;
    return k * hi * (64'sd1 <<< (24 - FRAC_BITS)) + round_q(k * lo);
  endfunction

  function automatic longint clamp(input longint v, input int w, inout bit ovf);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic frame_t build_frame(
    input longint ix, iy, bx, by, sx, sy, px, py,
    input logic [ANG_W-1:0] ang, input logic [1:0] nm, input longint col, rw
  );
    frame_t f;
    longint a32, z, x, y, dx, dy, cs, sn, sg, a, b, c, d, ox, oy, rx, ry, tx, ty;
    bit flip, ovf;
    f = '{default: '0};
    flip = 0;
    ovf = 0;
    if (col < 0 || rw < 0 || sx == 0 || sy == 0) begin
      f.st = ST_INVALID;
      return f;
    end
    if (nm != NORMAL_POS && nm != NORMAL_NEG) begin
      f.st = ST_UNSUP;
      return f;
    end
    a32 = longint'(ang) <<< 16;
    z = a32;
    x = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    y = 0;
    if (a32 >= (64'sd1 <<< 30) && a32 < (64'sd3 <<< 30)) begin
      z = a32 - (64'sd1 <<< 31);
      flip = 1;
    end else if (a32 >= (64'sd3 <<< 30)) begin
      z = a32 - (64'sd1 <<< 32);
    end
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    sg = (nm == NORMAL_NEG) ? -1 : 1;
    a = sg * round_q(cs * sx);
    b = round_q(sn * sx);
    c = -sg * round_q(sn * sy);
    d = round_q(cs * sy);
    ox = px * col;
    oy = py * rw;
    rx = sg * (scaled_mul(cs, ox) - scaled_mul(sn, oy));
    ry = scaled_mul(sn, ox) + scaled_mul(cs, oy);
    tx = sg * ix + rx - round_q(a * bx + c * by);
    ty = iy + ry - round_q(b * bx + d * by);
    f.ma = SC_W'(clamp(a, SC_W, ovf));
    f.mb = SC_W'(clamp(b, SC_W, ovf));
    f.mc = SC_W'(clamp(c, SC_W, ovf));
    f.md = SC_W'(clamp(d, SC_W, ovf));
    f.tx = PT_W'(clamp(tx, PT_W, ovf));
    f.ty = PT_W'(clamp(ty, PT_W, ovf));
    f.st = ovf ? ST_OVF : ST_OK;
    return f;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("frame %0d: %s got %0d want %0d", n_frames, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    n_frames = 0;
  end

  assign pending = frame_q.size();

  always @(posedge clk) begin
    frame_t e;
    if (!rst) begin
      if (start && !busy)
        frame_q.push_back(build_frame(ins_x, ins_y, base_x, base_y, scale_x, scale_y,
                                      spacing_x, spacing_y, angle, normal_mode, column, row));
      if (done) begin
        if (frame_q.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          e = frame_q.pop_front();
          if (matrix_a !== e.ma) report("matrix_a", matrix_a, e.ma);
          if (matrix_b !== e.mb) report("matrix_b", matrix_b, e.mb);
          if (matrix_c !== e.mc) report("matrix_c", matrix_c, e.mc);
          if (matrix_d !== e.md) report("matrix_d", matrix_d, e.md);
          if (shift_x !== e.tx) report("shift_x", shift_x, e.tx);
          if (shift_y !== e.ty) report("shift_y", shift_y, e.ty);
          if (status !== e.st) report("status", status, e.st);
        end
        n_frames++;
      end
    end
  end

endmodule

[verif/insert_frame_builder_top_tb.sv]
// testbench top of insert_frame_builder_top: directed and random transfers
// with sender idling phases; checking in insert_frame_builder_checker; uses ifb_pkg
module insert_frame_builder_top_tb;
  import ifb_pkg::*;

  localparam logic [1:0] NORMAL_UNSUP = 2'd2;
  localparam logic [1:0] NORMAL_ODD   = 2'd3;

  logic clk = 0, rst = 1, start = 0;
  logic signed [PT_W-1:0] ins_x = 0, ins_y = 0, base_x = 0, base_y = 0;
  logic signed [PT_W-1:0] spacing_x = 0, spacing_y = 0;
  logic signed [SC_W-1:0] scale_x = 0, scale_y = 0;
  logic [ANG_W-1:0]       angle = 0;
  logic [1:0]             normal_mode = 0;
  logic signed [ID_W-1:0] column = 0, row = 0;
  logic busy, done;
  logic signed [SC_W-1:0] matrix_a, matrix_b, matrix_c, matrix_d;
  logic signed [PT_W-1:0] shift_x, shift_y;
  logic [1:0]             status;
  int fail_count, pending;
  int idle_pct;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  insert_frame_builder_top dut (.*);
  insert_frame_builder_checker chk (.*);

  task automatic send_item(
    input logic [31:0] ix, iy, bx, by, input logic [23:0] sx, sy,
    input logic [31:0] px, py, input logic [15:0] ang, input logic [1:0] nm,
    input logic [15:0] col, rw
  );
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    ins_x <= ix; ins_y <= iy; base_x <= bx; base_y <= by;
    scale_x <= sx; scale_y <= sy; spacing_x <= px; spacing_y <= py;
    angle <= ang; normal_mode <= nm; column <= col; row <= rw;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h000FFFFF);
      2: return -$urandom_range(32'h000FFFFF);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(2))
      0: return 24'($urandom());
      1: return 24'($urandom_range(24'h03FFFF));
      default: return 24'(-$urandom_range(24'h03FFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_index();
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: return 16'($urandom_range(16'h7FFF));
      default: return 16'($urandom_range(20));
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] nm;
    logic [23:0] sx, sy;
    logic [15:0] col, rw;
    sx = pick_scale();
    sy = pick_scale();
    col = pick_index();
    rw = pick_index();
    nm = 2'($urandom_range(1));
    if ($urandom_range(19) == 0) nm = 2'($urandom_range(NORMAL_UNSUP, NORMAL_ODD));
    if ($urandom_range(29) == 0) sx = 0;
    if ($urandom_range(29) == 0) sy = 0;
    send_item(pick32(), pick32(), pick32(), pick32(), sx, sy, pick32(), pick32(),
              16'($urandom()), nm, col, rw);
  endtask

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: angles at quadrant edges, both normals, rejects, extremes
    send_item(0, 0, 0, 0, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_POS, 0, 0);
    send_item(32'h00010000, 32'h00020000, 32'h00008000, 32'hFFFF8000, 24'h010000,
              24'h020000, 32'h00030000, 32'h00010000, 16'h4000, NORMAL_POS, 2, 3);
    send_item(32'h00010000, 32'h00020000, 32'h00008000, 32'hFFFF8000, 24'h010000,
              24'h020000, 32'h00030000, 32'h00010000, 16'h8000, NORMAL_NEG, 2, 3);
    send_item(5, 7, 9, 11, 24'h018000, 24'hFF0000, 32'h100, 32'h200, 16'hC000,
              NORMAL_POS, 1, 1);
    send_item(5, 7, 9, 11, 24'h018000, 24'hFF0000, 32'h100, 32'h200, 16'h3FFF,
              NORMAL_NEG, 1, 1);
    send_item(5, 7, 9, 11, 24'h018000, 24'h010000, 32'h100, 32'h200, 16'hBFFF,
              NORMAL_POS, 4, 4);
    send_item(5, 7, 9, 11, 24'h018000, 24'h010000, 32'h100, 32'h200, 16'hFFFF,
              NORMAL_NEG, 4, 4);
    send_item(1, 1, 1, 1, 0, 24'h010000, 0, 0, 0, NORMAL_POS, 0, 0);
    send_item(1, 1, 1, 1, 24'h010000, 0, 0, 0, 0, NORMAL_POS, 0, 0);
    send_item(1, 1, 1, 1, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_POS, 16'hFFFF, 0);
    send_item(1, 1, 1, 1, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_UNSUP, 0, 16'h8000);
    send_item(1, 1, 1, 1, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_UNSUP, 0, 0);
    send_item(1, 1, 1, 1, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_ODD, 0, 0);
    send_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF,
              24'h800000, 32'h7FFFFFFF, 32'h80000000, 16'h2000, NORMAL_POS,
              16'h7FFF, 16'h7FFF);
    send_item(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'h800000,
              24'h7FFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hE000, NORMAL_NEG,
              16'h7FFF, 16'h7FFF);
    send_item(32'h7FFF0000, 0, 0, 0, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_POS, 0, 0);
    send_item(32'h80000000, 0, 0, 0, 24'h010000, 24'h010000, 0, 0, 0, NORMAL_NEG, 0, 0);
    send_item(0, 0, 0, 0, 24'h000001, 24'hFFFFFF, 32'hFFFFFFFF, 1, 16'h0001,
              NORMAL_POS, 16'h7FFF, 1);
    send_item(0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 16'h0000, NORMAL_POS, 0, 0);
    send_item(0, 0, 0, 0, 24'h800000, 24'h800000, 0, 0, 16'h8000, NORMAL_POS, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 22;
      endcase
      repeat (490) send_random();
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NSTAGE + 12) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("insert_frame_builder_top regression: pass");
    else
      $display("insert_frame_builder_top regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("insert_frame_builder_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/ifb_pkg.sv
hdl/insert_frame_builder_top.sv
verif/insert_frame_builder_checker.sv
verif/insert_frame_builder_top_tb.sv
